// ===== rtl/por_pkg.sv =====
// Shared constants for the positional ordered list unit.
// No dependencies; used by the interfaces and the top level.
package por_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_POS   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_OUT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

endpackage

// ===== rtl/por_if.sv =====
// Request and response channel interfaces of the positional ordered list unit.
// Depends on por_pkg for field widths.
interface por_req_if;
    logic                             valid;
    logic                             ready;
    logic [por_pkg::ACT_W-1:0]        action;
    logic [por_pkg::POS_W-1:0]        position;
    logic signed [por_pkg::DATA_W-1:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

interface por_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [por_pkg::STAT_W-1:0]        status;
    logic signed [por_pkg::DATA_W-1:0] item_value;
    logic [por_pkg::POS_W-1:0]         item_position;
    logic [por_pkg::POS_W-1:0]         length;
    logic                              last;

    modport source (output valid, status, item_value, item_position, length, last,
                    input ready);
    modport sink   (input valid, status, item_value, item_position, length, last,
                    output ready);
endinterface

// ===== rtl/positional_ordered_list_unit.sv =====
// Top level of the positional ordered list unit; depends on por_pkg and por_if.
// An insert shifts the later entries toward the back, then writes the new value into its slot;
// a delete shifts the later entries toward the front. Read-out returns the elements in order,
// one response each, and issues the next read only after the previous response is taken.
// Reset (synchronous, active low) empties the list; the store itself is not cleared.
module positional_ordered_list_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    por_req_if.sink        i_req,
    por_rsp_if.source      o_rsp
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1; // shift entries toward the back
    localparam logic [2:0] S_PUT  = 3'd2; // write the new value into its slot
    localparam logic [2:0] S_DN   = 3'd3; // shift entries toward the front
    localparam logic [2:0] S_RD   = 3'd4; // issue a read-out access
    localparam logic [2:0] S_RW   = 3'd5; // capture read-out data

    // Element store: one synchronous memory, one write and one registered read a cycle.
    logic [por_pkg::DATA_W-1:0] r_mem [por_pkg::CAPACITY];
    logic [por_pkg::DATA_W-1:0] r_rd_data;

    logic [2:0]                 r_state;
    logic [por_pkg::CNT_W-1:0]  r_count;
    logic [por_pkg::IDX_W-1:0]  r_ptr;    // address of the next read
    logic [por_pkg::IDX_W-1:0]  r_end;    // last read address of a shift, or insert slot
    logic                       r_rd_act; // reads of a shift still to issue
    logic                       r_pend;   // read data waits to be written back
    logic [por_pkg::IDX_W-1:0]  r_wa;
    logic [por_pkg::DATA_W-1:0] r_val;

    logic                        r_out_valid;
    logic [por_pkg::STAT_W-1:0]  r_out_status;
    logic [por_pkg::DATA_W-1:0]  r_out_item;
    logic [por_pkg::POS_W-1:0]   r_out_pos;
    logic [por_pkg::POS_W-1:0]   r_out_len;
    logic                        r_out_last;

    logic                        w_we;
    logic [por_pkg::IDX_W-1:0]   w_wa;
    logic [por_pkg::DATA_W-1:0]  w_wd;
    logic                        w_re;
    logic                        w_acc;
    logic                        w_take;
    logic [por_pkg::CNT_W:0]     w_cnt_p1;
    logic [por_pkg::IDX_W-1:0]   w_pos_idx;
    logic [por_pkg::IDX_W-1:0]   w_cnt_idx;
    logic [por_pkg::IDX_W-1:0]   w_last_idx;
    logic [por_pkg::IDX_W-1:0]   w_ins_idx;
    logic                        w_pos_zero;

    assign w_acc  = i_req.valid && i_req.ready;
    assign w_take = o_rsp.valid && o_rsp.ready;

    // A new request is taken only when the sequencer is idle and the response slot is free.
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.item_value    = r_out_item;
    assign o_rsp.item_position = r_out_pos;
    assign o_rsp.length        = r_out_len;
    assign o_rsp.last          = r_out_last;

    assign w_cnt_p1   = {1'b0, r_count} + 1'b1;
    assign w_pos_zero = (i_req.position == '0);
    assign w_pos_idx  = por_pkg::IDX_W'(i_req.position - 1'b1);
    assign w_cnt_idx  = r_count[por_pkg::IDX_W-1:0];
    assign w_last_idx = por_pkg::IDX_W'(r_count - 1'b1);

    always_comb begin
        case (i_req.action)
            por_pkg::ACT_INS_FRONT: w_ins_idx = '0;
            por_pkg::ACT_INS_BACK:  w_ins_idx = w_cnt_idx;
            default:                w_ins_idx = w_pos_idx;
        endcase
    end

    // Write port: pending shift data, or the inserted value at the end of an insert.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_wa;
        w_wd = r_rd_data;
        if ((r_state == S_UP || r_state == S_DN) && r_pend) begin
            w_we = 1'b1;
        end else if (r_state == S_PUT) begin
            w_we = 1'b1;
            w_wa = r_end;
            w_wd = r_val;
        end
    end

    assign w_re = ((r_state == S_UP || r_state == S_DN) && r_rd_act)
                  || (r_state == S_RD && !r_out_valid);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_act    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out_item <= '0;
                        r_out_pos  <= '0;
                        r_out_last <= 1'b1;
                        r_val      <= i_req.value;
                        case (i_req.action)
                            por_pkg::ACT_INS_FRONT, por_pkg::ACT_INS_BACK,
                            por_pkg::ACT_INS_POS: begin
                                if (r_count == por_pkg::CNT_W'(por_pkg::CAPACITY)) begin
                                    r_out_status <= por_pkg::ST_FULL;
                                    r_out_len    <= r_count;
                                    r_out_valid  <= 1'b1;
                                end else if (i_req.action == por_pkg::ACT_INS_POS &&
                                             (w_pos_zero ||
                                              {1'b0, i_req.position} > w_cnt_p1)) begin
                                    r_out_status <= por_pkg::ST_RANGE;
                                    r_out_len    <= r_count;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_end <= w_ins_idx;
                                    if (w_ins_idx == w_cnt_idx) begin
                                        r_state <= S_PUT;
                                    end else begin
                                        r_ptr    <= w_last_idx;
                                        r_rd_act <= 1'b1;
                                        r_pend   <= 1'b0;
                                        r_state  <= S_UP;
                                    end
                                end
                            end
                            por_pkg::ACT_DEL_POS: begin
                                if (r_count == '0) begin
                                    r_out_status <= por_pkg::ST_EMPTY;
                                    r_out_len    <= r_count;
                                    r_out_valid  <= 1'b1;
                                end else if (w_pos_zero || i_req.position > r_count) begin
                                    r_out_status <= por_pkg::ST_RANGE;
                                    r_out_len    <= r_count;
                                    r_out_valid  <= 1'b1;
                                end else if (w_pos_idx == w_last_idx) begin
                                    // Removing the tail moves nothing.
                                    r_count      <= r_count - 1'b1;
                                    r_out_len    <= r_count - 1'b1;
                                    r_out_status <= por_pkg::ST_OK;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_ptr    <= w_pos_idx + 1'b1;
                                    r_end    <= w_last_idx;
                                    r_rd_act <= 1'b1;
                                    r_pend   <= 1'b0;
                                    r_state  <= S_DN;
                                end
                            end
                            por_pkg::ACT_READ_OUT: begin
                                if (r_count == '0) begin
                                    r_out_status <= por_pkg::ST_EMPTY;
                                    r_out_len    <= r_count;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_ptr   <= '0;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_out_status <= por_pkg::ST_OK;
                                r_out_len    <= r_count;
                                r_out_valid  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_UP, S_DN: begin
                    // Each read is written back in the cycle after it is issued; read and write
                    // addresses never meet, so no forwarding is needed.
                    if (r_rd_act) begin
                        r_pend <= 1'b1;
                        if (r_state == S_UP) begin
                            r_wa <= r_ptr + 1'b1;
                        end else begin
                            r_wa <= r_ptr - 1'b1;
                        end
                        if (r_ptr == r_end) begin
                            r_rd_act <= 1'b0;
                        end else if (r_state == S_UP) begin
                            r_ptr <= r_ptr - 1'b1;
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                        if (r_pend && r_state == S_DN) begin
                            r_count      <= r_count - 1'b1;
                            r_out_len    <= r_count - 1'b1;
                            r_out_status <= por_pkg::ST_OK;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (r_pend) begin
                            r_state <= S_PUT;
                        end
                    end
                end
                S_PUT: begin
                    r_count      <= r_count + 1'b1;
                    r_out_len    <= r_count + 1'b1;
                    r_out_status <= por_pkg::ST_OK;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_RD: begin
                    if (!r_out_valid) begin
                        r_state <= S_RW;
                    end
                end
                S_RW: begin
                    r_out_status <= por_pkg::ST_OK;
                    r_out_item   <= r_rd_data;
                    r_out_pos    <= por_pkg::POS_W'(r_ptr) + 1'b1;
                    r_out_len    <= r_count;
                    r_out_last   <= (r_ptr == w_last_idx);
                    r_out_valid  <= 1'b1;
                    if (r_ptr == w_last_idx) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
